// ===== hdl/mpt_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI pedal tracker package
// Shared types, byte codes and decode helpers for the pedal tracker.
// ----------------------------------------------------------------------------
package mpt_pkg;

    typedef enum logic [1:0] {
        PH_TAG   = 2'd0,
        PH_HEAD  = 2'd1,
        PH_DATA1 = 2'd2,
        PH_DATA2 = 2'd3
    } t_phase;

    localparam logic [7:0] C_TIME_OVERFLOW = 8'hF8;
    localparam logic [7:0] C_STATUS_BIT    = 8'h80;
    localparam logic [7:0] C_ONE_DATA_LO   = 8'hC0;
    localparam logic [7:0] C_ONE_DATA_HI   = 8'hDF;
    localparam logic [7:0] C_MARK_MIN      = 8'hF0;
    localparam logic [3:0] C_CTRL_CHANGE   = 4'hB;
    localparam logic [7:0] C_CC_SUSTAIN    = 8'h40;
    localparam logic [7:0] C_CC_PORTAMENTO = 8'h41;

    typedef struct packed {
        logic [7:0] sustain_level;
        logic [7:0] portamento_level;
        logic       event_done;
        logic       pedal_updated;
    } t_result;

    function automatic logic one_data_byte(input logic [7:0] status);
        return status inside {[C_ONE_DATA_LO:C_ONE_DATA_HI]};
    endfunction

    function automatic logic is_status(input logic [7:0] value);
        return (value & C_STATUS_BIT) != 8'h00;
    endfunction

endpackage

// ===== hdl/mpt_if.sv =====
// ----------------------------------------------------------------------------
// MIDI pedal tracker channel interfaces
// Valid/ready channels for the byte stream and for the pedal results.
// ----------------------------------------------------------------------------
interface mpt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface mpt_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] sustain_level;
    logic [7:0] portamento_level;
    logic       event_done;
    logic       pedal_updated;

    modport source (output valid, output sustain_level, output portamento_level,
                    output event_done, output pedal_updated, input ready);
    modport sink   (input valid, input sustain_level, input portamento_level,
                    input event_done, input pedal_updated, output ready);
endinterface

// ===== hdl/midi_pedal_tracker_top.sv =====
// ----------------------------------------------------------------------------
// MIDI pedal tracker top level
// Parses a timed MIDI byte stream and tracks the sustain and portamento pedals.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the result sink is ready and
// returns exactly one result per byte, through the input and result registers.
// The byte is registered, decoded combinationally by the running-status parser
// and written into the result register; that single decode step sets the rate.
// While a finished result waits for the sink, the input register can still
// take one more byte; the stream then stops until the sink takes the result.
module midi_pedal_tracker_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mpt_byte_if.sink     i_byte,
    mpt_result_if.source o_result
);
    import mpt_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       can_load;
    logic       step;
    t_result    result;

    assign step         = r_in_valid && can_load;
    assign i_byte.ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.byte_in;
        end
    end

    mpt_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    mpt_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_in_valid),
        .i_result   (result),
        .o_can_load (can_load),
        .o_result   (o_result)
    );

endmodule

// ===== hdl/mpt_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI pedal tracker parser
// Running-status parser state and the per-byte decode of one timed event.
// ----------------------------------------------------------------------------
module mpt_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output mpt_pkg::t_result o_result
);
    import mpt_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_status, n_status;
    logic [7:0] r_first, n_first;
    logic [7:0] r_sustain, n_sustain;
    logic [7:0] r_porta, n_porta;
    logic       done;
    logic       upd;

    always_comb begin
        n_phase   = r_phase;
        n_status  = r_status;
        n_first   = r_first;
        n_sustain = r_sustain;
        n_porta   = r_porta;
        done      = 1'b0;
        upd       = 1'b0;
        case (r_phase)
            PH_TAG: begin
                if (i_byte == C_TIME_OVERFLOW) begin
                    done = 1'b1;
                end else begin
                    n_phase = PH_HEAD;
                end
            end
            PH_HEAD: begin
                if (!is_status(i_byte)) begin
                    n_first = i_byte;
                    if (one_data_byte(r_status)) begin
                        done    = 1'b1;
                        n_phase = PH_TAG;
                    end else begin
                        n_phase = PH_DATA2;
                    end
                end else begin
                    n_status = i_byte;
                    if (i_byte >= C_MARK_MIN) begin
                        done    = 1'b1;
                        n_phase = PH_TAG;
                    end else begin
                        n_phase = PH_DATA1;
                    end
                end
            end
            PH_DATA1: begin
                n_first = i_byte;
                if (one_data_byte(r_status)) begin
                    done    = 1'b1;
                    n_phase = PH_TAG;
                end else begin
                    n_phase = PH_DATA2;
                end
            end
            PH_DATA2: begin
                done    = 1'b1;
                n_phase = PH_TAG;
                if (r_status[7:4] == C_CTRL_CHANGE) begin
                    if (r_first == C_CC_SUSTAIN) begin
                        n_sustain = i_byte;
                        upd       = 1'b1;
                    end else if (r_first == C_CC_PORTAMENTO) begin
                        n_porta = i_byte;
                        upd     = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG;
            r_status  <= 8'h00;
            r_first   <= 8'h00;
            r_sustain <= 8'h00;
            r_porta   <= 8'h00;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_status  <= n_status;
            r_first   <= n_first;
            r_sustain <= n_sustain;
            r_porta   <= n_porta;
        end
    end

    assign o_result.sustain_level    = n_sustain;
    assign o_result.portamento_level = n_porta;
    assign o_result.event_done       = done;
    assign o_result.pedal_updated    = upd;

endmodule

// ===== hdl/mpt_out_reg.sv =====
// ----------------------------------------------------------------------------
// MIDI pedal tracker result register
// Holds one result until the sink takes it and reports when it can load.
// ----------------------------------------------------------------------------
module mpt_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mpt_pkg::t_result i_result,
    output logic             o_can_load,
    mpt_result_if.source     o_result
);
    import mpt_pkg::*;

    logic    r_valid, n_valid;
    t_result r_data;

    assign o_can_load = !r_valid || o_result.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_can_load) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_data <= i_result;
        end
    end

    assign o_result.valid            = r_valid;
    assign o_result.sustain_level    = r_data.sustain_level;
    assign o_result.portamento_level = r_data.portamento_level;
    assign o_result.event_done       = r_data.event_done;
    assign o_result.pedal_updated    = r_data.pedal_updated;

endmodule

// ===== hdl/mpt_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI pedal tracker checker
// Port-level assertions on the pedal tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mpt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_sustain,
    input logic [7:0] i_porta,
    input logic       i_done,
    input logic       i_updated
);
    logic       r_seen;
    logic [7:0] r_last_sustain;
    logic [7:0] r_last_porta;
    logic       out_xfer;

    assign out_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen         <= 1'b0;
            r_last_sustain <= 8'h00;
            r_last_porta   <= 8'h00;
        end else if (out_xfer) begin
            r_seen         <= 1'b1;
            r_last_sustain <= i_sustain;
            r_last_porta   <= i_porta;
        end
    end

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sustain)
            && $stable(i_porta) && $stable(i_done) && $stable(i_updated))
        else $error("Stalled result changed.");

    a_update_ends_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && i_updated |-> i_done)
        else $error("Pedal update outside the end of an event.");

    a_levels_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !i_updated |-> i_sustain == r_last_sustain
            && i_porta == r_last_porta)
        else $error("Pedal level changed without an update.");

    a_one_pedal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && i_updated && r_seen |-> i_sustain == r_last_sustain
            || i_porta == r_last_porta)
        else $error("Both pedal levels changed in one transaction.");

endmodule

bind midi_pedal_tracker_top mpt_checker u_mpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_sustain   (o_result.sustain_level),
    .i_porta     (o_result.portamento_level),
    .i_done      (o_result.event_done),
    .i_updated   (o_result.pedal_updated)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// MIDI pedal tracker testbench
// Drives timed MIDI byte streams into the pedal tracker and checks every
// result against a running-status parser kept in a scoreboard. A directed
// opening covers tags, marks, running status and both pedals. It is followed
// by random events with noise, and random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
    import mpt_pkg::*;

    class pedal_scoreboard;
        t_phase     parse_phase;
        logic [7:0] last_status;
        logic [7:0] data0;
        logic [7:0] sustain;
        logic [7:0] portamento;
        t_result    pending_results [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned events_done;
        int unsigned pedal_writes;

        function new();
            parse_phase  = PH_TAG;
            last_status  = 8'h00;
            data0        = 8'h00;
            sustain      = 8'h00;
            portamento   = 8'h00;
            mismatches   = 0;
            results_seen = 0;
            events_done  = 0;
            pedal_writes = 0;
        endfunction

        function bit takes_one_data(input logic [7:0] st);
            return st >= C_ONE_DATA_LO && st <= C_ONE_DATA_HI;
        endfunction

        function void flag(input string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void take_byte(input logic [7:0] b);
            t_result r;
            logic    done;
            logic    upd;
            done = 1'b0;
            upd  = 1'b0;
            case (parse_phase)
                PH_TAG: begin
                    if (b == C_TIME_OVERFLOW) begin
                        done = 1'b1;
                    end else begin
                        parse_phase = PH_HEAD;
                    end
                end
                PH_HEAD: begin
                    if ((b & C_STATUS_BIT) == 8'h00) begin
                        data0 = b;
                        if (takes_one_data(last_status)) begin
                            done = 1'b1;
                            parse_phase = PH_TAG;
                        end else begin
                            parse_phase = PH_DATA2;
                        end
                    end else begin
                        last_status = b;
                        if (b >= C_MARK_MIN) begin
                            done = 1'b1;
                            parse_phase = PH_TAG;
                        end else begin
                            parse_phase = PH_DATA1;
                        end
                    end
                end
                PH_DATA1: begin
                    data0 = b;
                    if (takes_one_data(last_status)) begin
                        done = 1'b1;
                        parse_phase = PH_TAG;
                    end else begin
                        parse_phase = PH_DATA2;
                    end
                end
                default: begin
                    if (last_status[7:4] == C_CTRL_CHANGE) begin
                        if (data0 == C_CC_SUSTAIN) begin
                            sustain = b;
                            upd = 1'b1;
                        end else if (data0 == C_CC_PORTAMENTO) begin
                            portamento = b;
                            upd = 1'b1;
                        end
                    end
                    done = 1'b1;
                    parse_phase = PH_TAG;
                end
            endcase
            if (done) events_done++;
            if (upd) pedal_writes++;
            r.sustain_level    = sustain;
            r.portamento_level = portamento;
            r.event_done       = done;
            r.pedal_updated    = upd;
            pending_results.push_back(r);
        endfunction

        function void check_result(input t_result got);
            t_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                flag($sformatf("tb: result with none expected: sus=%02h por=%02h done=%b upd=%b",
                               got.sustain_level, got.portamento_level,
                               got.event_done, got.pedal_updated));
                return;
            end
            want = pending_results.pop_front();
            if (got.sustain_level !== want.sustain_level
                    || got.portamento_level !== want.portamento_level
                    || got.event_done !== want.event_done
                    || got.pedal_updated !== want.pedal_updated) begin
                flag($sformatf({"tb: result %0d mismatch: expected sus=%02h por=%02h done=%b ",
                                "upd=%b, got sus=%02h por=%02h done=%b upd=%b"},
                               results_seen, want.sustain_level, want.portamento_level,
                               want.event_done, want.pedal_updated, got.sustain_level,
                               got.portamento_level, got.event_done, got.pedal_updated));
            end
        endfunction

        function void close_out();
            if (pending_results.size() != 0) begin
                flag($sformatf("tb: %0d expected results never arrived",
                               pending_results.size()));
            end
        endfunction
    endclass

    localparam int unsigned C_LIMIT = 1_000_000;
    localparam int unsigned C_BYTES = 1700;

    logic i_clk;
    logic i_rst_n;

    mpt_byte_if   byte_ch ();
    mpt_result_if res_ch ();

    midi_pedal_tracker_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (res_ch)
    );

    pedal_scoreboard sb;
    bit              no_idle;
    int unsigned     bytes_sent;
    int unsigned     cycle_count;
    int unsigned     next_switch;
    logic [7:0]      opening [$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 31);
        if (roll < 18) return 0;
        if (roll < 28) return $urandom_range(1, 3);
        if (roll < 31) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        sb.take_byte(b);
        bytes_sent++;
        gap = idle_gap();
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] status_byte();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return {C_CTRL_CHANGE, 4'($urandom_range(0, 15))};
        if (roll < 6) return 8'($urandom_range(C_ONE_DATA_LO, C_ONE_DATA_HI));
        if (roll < 9) return 8'($urandom_range(8'h80, 8'hEF));
        return 8'($urandom_range(C_MARK_MIN, 8'hFF));
    endfunction

    function automatic logic [7:0] data_byte(input bit first);
        int unsigned roll;
        if (first && sb.last_status[7:4] == C_CTRL_CHANGE && $urandom_range(0, 3) != 0) begin
            return $urandom_range(0, 1) ? C_CC_SUSTAIN : C_CC_PORTAMENTO;
        end
        roll = $urandom_range(0, 7);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'h7F;
        if (roll == 2) return 8'hFF;
        if (roll < 5) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic random_event();
        int unsigned roll;
        logic [7:0]  tag;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            send_byte(C_TIME_OVERFLOW);
        end else if (roll < 16) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            tag = 8'($urandom_range(0, 255));
            if (tag == C_TIME_OVERFLOW) tag = 8'h00;
            send_byte(tag);
            if ($urandom_range(0, 9) < 4) begin
                send_byte(data_byte(1'b1));
            end else begin
                send_byte(status_byte());
            end
        end
        while (sb.parse_phase != PH_TAG) begin
            send_byte(data_byte(sb.parse_phase != PH_DATA2));
        end
    endtask

    initial begin
        res_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            int unsigned gap;
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            gap = idle_gap();
            if (gap != 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got.sustain_level    = res_ch.sustain_level;
            got.portamento_level = res_ch.portamento_level;
            got.event_done       = res_ch.event_done;
            got.pedal_updated    = res_ch.pedal_updated;
            sb.check_result(got);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < C_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        sb          = new();
        no_idle     = 1'b0;
        bytes_sent  = 0;
        next_switch = 0;
        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.byte_in <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Data before any status and data after a mark both take the
        // two-data-byte path without touching a pedal.
        opening = '{C_TIME_OVERFLOW,
                    8'h00, 8'h05, C_CC_SUSTAIN,
                    8'h10, {C_CTRL_CHANGE, 4'h0}, C_CC_SUSTAIN, 8'h7F,
                    8'h7F, C_CC_PORTAMENTO, 8'hFF,
                    8'h20, C_ONE_DATA_LO, 8'h80,
                    8'h21, 8'h00,
                    8'h22, C_ONE_DATA_HI, 8'h12,
                    8'hFF, C_MARK_MIN,
                    8'h01, C_CC_SUSTAIN, 8'h00,
                    8'h02, {C_CTRL_CHANGE, 4'hF}, C_CC_SUSTAIN, 8'h00};
        foreach (opening[i]) send_byte(opening[i]);

        while (bytes_sent < C_BYTES) begin
            if (bytes_sent >= next_switch) begin
                no_idle     = ($urandom_range(0, 3) == 0);
                next_switch = bytes_sent + $urandom_range(80, 200);
            end
            random_event();
        end
        no_idle = 1'b0;
        byte_ch.valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        sb.close_out();

        $display("tb: %0d bytes streamed, %0d results checked, %0d events completed",
                 bytes_sent, sb.results_seen, sb.events_done);
        $display("tb: %0d pedal writes, %0d mismatches", sb.pedal_writes, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
